FILE: hdl/kear_pkg.sv
// Shared types and constants for the key edge and auto-repeat block.
// No dependencies.
package kear_pkg;

    localparam int KEY_W      = 8;
    localparam int CFG_W      = 8;
    localparam int OUT_HOLD_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic REG_FIRST_DELAY     = 1'b0;
    localparam logic REG_REPEAT_INTERVAL = 1'b1;

    localparam logic [CFG_W-1:0] RST_FIRST_DELAY     = 8'd10;
    localparam logic [CFG_W-1:0] RST_REPEAT_INTERVAL = 8'd2;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_SYNC   = 1'b1;

    typedef struct packed {
        logic             mode;
        logic             pressed;
        logic             in_range;
        logic [KEY_W-1:0] key_code;
    } t_item;

    typedef struct packed {
        logic [CFG_W-1:0] delay;
        logic [CFG_W-1:0] interval;
    } t_cfg;

    typedef struct packed {
        logic [OUT_HOLD_W-1:0] hold_frames;
        logic                  move_event;
        logic                  repeat_pulse;
        logic                  trigger;
    } t_result;

endpackage

FILE: hdl/kear_front.sv
// Input side: accepts sampled keys, range-checks the key code and builds queue requests.
// Depends on kear_pkg.
module kear_front
    import kear_pkg::*;
#(
    parameter int NUM_KEYS = 256
) (
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,   // [7:0] key_code, [8] pressed, [15:9] zero
    input  logic                 s_axis_tuser,   // [0] mode
    input  logic                 i_q_full,
    input  logic                 i_clr_done,
    output logic                 o_push,
    output t_item                o_item
);

    logic in_range;

    assign in_range      = 32'(s_axis_tdata[KEY_W-1:0]) < NUM_KEYS;
    assign s_axis_tready = i_clr_done && !i_q_full;
    assign o_push        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        o_item.mode     = s_axis_tuser;
        o_item.pressed  = s_axis_tdata[KEY_W];
        o_item.in_range = in_range;
        // steer out-of-range keys to entry zero; they never write
        o_item.key_code = in_range ? s_axis_tdata[KEY_W-1:0] : '0;
    end

endmodule

FILE: hdl/kear_queue.sv
// Two-entry request queue between the input side and the key engine.
// Depends on kear_pkg.
module kear_queue
    import kear_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_head,
    output logic  o_empty
);

    t_item       r_entry [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_head  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/kear_back.sv
// Key engine: per-key level/hold memory, hold update, iterative repeat test, result register.
// Depends on kear_pkg.
module kear_back
    import kear_pkg::*;
#(
    parameter int NUM_KEYS   = 256,
    parameter int HOLD_WIDTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_empty,
    input  t_item   i_q_head,
    output logic    o_q_pop,
    output logic    o_clr_done,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out
);

    localparam int KW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int STEPS = (HOLD_WIDTH + 1) / 2;
    localparam int DW    = 2 * STEPS;
    localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CALC  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    function automatic logic [CFG_W-1:0] rem_step(input logic [CFG_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [CFG_W-1:0] div);
        logic [CFG_W:0] t;
        logic [CFG_W:0] d;
        t = {rem, bit_in};
        d = {1'b0, div};
        if (t >= d) begin
            t = t - d;
        end
        return t[CFG_W-1:0];
    endfunction

    logic [HOLD_WIDTH:0]   mem [NUM_KEYS];
    logic [HOLD_WIDTH:0]   r_rdata;
    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [KW-1:0]         r_clr;
    t_item                 r_item;
    logic [HOLD_WIDTH-1:0] r_hold;
    logic                  r_trig;
    logic                  r_rep;
    logic [DW-1:0]         r_dvd;
    logic [CFG_W-1:0]      r_rem;
    logic [CW-1:0]         r_cnt;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  mem_we;
    logic [KW-1:0]         mem_wa;
    logic [HOLD_WIDTH:0]   mem_wd;
    logic                  old_lvl;
    logic [HOLD_WIDTH-1:0] old_hold;
    logic [HOLD_WIDTH-1:0] inc_hold;
    logic [HOLD_WIDTH-1:0] new_hold;
    logic [HOLD_WIDTH-1:0] diff;
    logic                  trig;
    logic                  need_div;
    logic [CFG_W-1:0]      rem_a;
    logic [CFG_W-1:0]      rem_b;
    logic                  load_out;

    assign o_clr_done  = r_state != ST_CLEAR;
    assign o_q_pop     = (r_state == ST_IDLE) && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign load_out    = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        old_lvl  = r_rdata[HOLD_WIDTH];
        old_hold = r_rdata[HOLD_WIDTH-1:0];
        inc_hold = (old_hold == '1) ? old_hold : old_hold + HOLD_WIDTH'(1);
        new_hold = '0;
        trig     = 1'b0;
        need_div = 1'b0;
        if (r_item.in_range) begin
            if (r_item.mode == MODE_SYNC) begin
                new_hold = HOLD_WIDTH'(r_item.pressed);
            end else begin
                new_hold = r_item.pressed ? inc_hold : '0;
                trig     = r_item.pressed && !old_lvl;
                need_div = r_item.pressed && (new_hold > HOLD_WIDTH'(i_cfg.delay));
            end
        end
        diff = new_hold - HOLD_WIDTH'(i_cfg.delay);
    end

    assign rem_a = rem_step(r_rem, r_dvd[DW-1], i_cfg.interval);
    assign rem_b = rem_step(rem_a, r_dvd[DW-2], i_cfg.interval);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr;
        mem_wd = '0;
        if (r_state == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == ST_CALC) begin
            mem_we = r_item.in_range;
            mem_wa = KW'(r_item.key_code);
            mem_wd = {r_item.pressed, new_hold};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[KW'(i_q_head.key_code)];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == KW'(NUM_KEYS - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (!i_q_empty) n_state = ST_CALC;
            ST_CALC:  n_state = need_div ? ST_DIV : ST_DONE;
            ST_DIV:   if (r_cnt == '0) n_state = ST_DONE;
            ST_DONE:  if (load_out) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + KW'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_item <= i_q_head;
            end
            ST_CALC: begin
                r_hold <= new_hold;
                r_trig <= trig;
                r_rep  <= 1'b0;
                r_dvd  <= DW'(diff);
                r_rem  <= '0;
                r_cnt  <= CW'(STEPS - 1);
            end
            ST_DIV: begin
                r_rem <= rem_b;
                r_dvd <= r_dvd << 2;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_rep <= rem_b == '0;
                end
            end
            default: begin
            end
        endcase
        if (load_out) begin
            r_out.trigger      <= r_trig;
            r_out.repeat_pulse <= r_rep;
            r_out.move_event   <= r_trig | r_rep;
            r_out.hold_frames  <= OUT_HOLD_W'(r_hold);
        end
    end

endmodule

FILE: hdl/key_edge_and_auto_repeat.sv
// Key press edge and typematic auto-repeat, one result per sampled key.
// Per key: queue entry, key memory read, hold update and, for a held key past the first delay,
// the repeat test (a 2-bit/cycle remainder), then the result register.
// The engine takes the next key from the queue only once the last key's result is registered.
// Reset: synchronous; a clearing pass zeroes all NUM_KEYS key memory entries, input held off.
// Depends on kear_pkg, kear_front, kear_queue, kear_back.
module key_edge_and_auto_repeat
    import kear_pkg::*;
#(
    parameter int NUM_KEYS   = 256,
    parameter int HOLD_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] key_code, [8] pressed, [15:9] zero
    input  logic                  s_axis_tuser,   // [0] mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [0] trigger, [1] repeat_pulse,
                                                  // [2] move_event, [18:3] hold_frames,
                                                  // [23:19] zero
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] r_first_delay;
    logic [CFG_W-1:0] r_repeat_interval;
    t_cfg             cfg;
    t_item            push_item;
    t_item            q_head;
    t_result          result;
    logic             push;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;
    logic             clr_done;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_delay     <= RST_FIRST_DELAY;
            r_repeat_interval <= RST_REPEAT_INTERVAL;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_FIRST_DELAY:     r_first_delay     <= pwdata[CFG_W-1:0];
                REG_REPEAT_INTERVAL: r_repeat_interval <= pwdata[CFG_W-1:0];
                default:             r_first_delay     <= r_first_delay;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FIRST_DELAY:     prdata = APB_DATA_W'(r_first_delay);
            REG_REPEAT_INTERVAL: prdata = APB_DATA_W'(r_repeat_interval);
            default:             prdata = '0;
        endcase
    end

    always_comb begin
        cfg.delay    = (r_first_delay == '0) ? CFG_W'(1) : r_first_delay;
        cfg.interval = (r_repeat_interval == '0) ? CFG_W'(1) : r_repeat_interval;
    end

    kear_front #(
        .NUM_KEYS (NUM_KEYS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .i_clr_done    (clr_done),
        .o_push        (push),
        .o_item        (push_item)
    );

    kear_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    kear_back #(
        .NUM_KEYS   (NUM_KEYS),
        .HOLD_WIDTH (HOLD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_clr_done  (clr_done),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (result)
    );

    assign m_axis_tdata = OUT_DATA_W'(result);

endmodule

FILE: hdl/kear_checker.sv
// Port-level checks for key_edge_and_auto_repeat, attached by bind.
// Depends on kear_pkg.
module kear_checker
    import kear_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_move_or: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2] == (m_axis_tdata[0] | m_axis_tdata[1]))
        else $error("move_event is not trigger or repeat");

    a_trig_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[18:3] == 16'd1 && !m_axis_tdata[1])
        else $error("press edge without a fresh hold count");

    a_rst_block: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input accepted during memory clear");

endmodule

bind key_edge_and_auto_repeat kear_checker u_kear_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
